>>> rtl/core/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	localparam int ARENA_WORDS  = 65536;
	localparam int HANDLE_SLOTS = 64;

	localparam int CMD_W   = 2;
	localparam int KEY_W   = 32;
	localparam int REQ_W   = 17;
	localparam int START_W = 17;
	localparam int STAT_W  = 2;

	// tree geometry: power-of-two leaf count, node 1 is the root
	localparam int LEAF_W = $clog2(ARENA_WORDS);
	localparam int LEAVES = 1 << LEAF_W;
	localparam int NODE_W = LEAF_W + 1;
	localparam int IDX_W  = LEAF_W;
	localparam int POS_W  = $clog2(ARENA_WORDS + 1);
	localparam int SLOT_W = $clog2(HANDLE_SLOTS);
	localparam int SLOT_WORD_W = KEY_W + 2 * POS_W;

	localparam logic [POS_W-1:0] ARENA_POS = POS_W'(ARENA_WORDS);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_NOFIT = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SCAN_LAST,
		S_DECIDE,
		S_A_ROOT_RD,
		S_A_ROOT_CK,
		S_A_DESC_RD,
		S_A_DESC_CK,
		S_A_FOUND_RD,
		S_A_FOUND_CK,
		S_A_SPLIT,
		S_A_FAIL,
		S_F_START,
		S_F_NXT_CK,
		S_F_PRV_RD,
		S_F_PRV_CK,
		S_F_PS_CK,
		S_F_PUT,
		S_LEAF_WR,
		S_UP_RD,
		S_UP_WR,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/ffa_cmd_if.sv
`default_nettype none
interface ffa_cmd_if import ffa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [KEY_W-1:0]   handle_name;
	logic [REQ_W-1:0]   request_length;

	modport source(output valid, command, handle_name, request_length, input ready);
	modport sink(input valid, command, handle_name, request_length, output ready);
endinterface
`default_nettype wire

>>> rtl/core/ffa_rsp_if.sv
`default_nettype none
interface ffa_rsp_if import ffa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [START_W-1:0] start_position;
	logic [STAT_W-1:0]  status;

	modport source(output valid, start_position, status, input ready);
	modport sink(input valid, start_position, status, output ready);
endinterface
`default_nettype wire

>>> rtl/core/first_fit_block_allocator.sv
`default_nettype none
// First-fit block allocator with coalescing over arena positions 1..ARENA_WORDS.
// cmd channel: one beat per command (allocate, free, query) on a 32-bit handle.
// rsp channel: exactly one beat per command with start_position and status.
// Both channels use valid/ready; a beat moves when both are high.
// After reset the block runs a clearing pass over all 2*LEAVES tree memory
// words with cmd.ready low; the same pass sets the arena up as one free block.
// Commands are handled one at a time. Every command first scans the handle
// table, one slot a cycle. Allocate then descends the max tree, reading one
// node per level, and rewrites up to two leaves; each leaf update walks to
// the root. Free rewrites up to three leaves. How long a command takes is
// set by the single read port of the tree memory and the slot scan.
// The result sits in an output register; the next command is accepted while
// it waits, and a second result is held back until rsp.ready takes the first.
module first_fit_block_allocator import ffa_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	ffa_cmd_if.sink   cmd,
	ffa_rsp_if.source rsp
);

	state_t state_q, state_d, ret_q;

	// memories
	logic                   tree_we;
	logic [NODE_W-1:0]      tree_waddr, tree_raddr;
	logic [POS_W-1:0]       tree_wdata, tree_rdata;
	logic                   fl_we;
	logic [IDX_W-1:0]       fl_waddr, fl_raddr;
	logic [POS_W-1:0]       fl_wdata, fl_rdata;
	logic                   fse_we;
	logic [IDX_W-1:0]       fse_waddr, fse_raddr;
	logic [POS_W-1:0]       fse_wdata, fse_rdata;
	logic                   slot_we;
	logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
	logic [SLOT_WORD_W-1:0] slot_wdata, slot_rdata;

	ffa_ram #(.DEPTH(2 * LEAVES), .WIDTH(POS_W)) u_tree (
		.clk(clk), .we(tree_we), .waddr(tree_waddr), .wdata(tree_wdata),
		.raddr(tree_raddr), .rdata(tree_rdata)
	);
	ffa_ram #(.DEPTH(ARENA_WORDS), .WIDTH(POS_W)) u_len_at_start (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rdata)
	);
	ffa_ram #(.DEPTH(ARENA_WORDS), .WIDTH(POS_W)) u_start_at_end (
		.clk(clk), .we(fse_we), .waddr(fse_waddr), .wdata(fse_wdata),
		.raddr(fse_raddr), .rdata(fse_rdata)
	);
	ffa_ram #(.DEPTH(HANDLE_SLOTS), .WIDTH(SLOT_WORD_W)) u_slots (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	// control
	logic [NODE_W-1:0]       clr_q;
	logic [HANDLE_SLOTS-1:0] used_q;
	logic                    out_vld_q;
	logic [SLOT_W-1:0]       scan_idx_q;
	logic                    chk_vld_s1;
	logic [SLOT_W-1:0]       chk_idx_s1;
	logic                    found_q, free_found_q;

	// payload
	cmd_t               cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [REQ_W-1:0]   req_q;
	logic [POS_W-1:0]   len_q;
	logic [SLOT_W-1:0]  fslot_q, free_slot_q, slot_q;
	logic [POS_W-1:0]   hit_start_q, hit_end_q;
	logic [NODE_W-1:0]  node_q;
	logic [POS_W-1:0]   cur_q, pos_q, blen_q, bend_q, s_q, e_q, ps_q;
	logic [IDX_W-1:0]   leaf_idx_q;
	logic [POS_W-1:0]   leaf_v_q;
	logic [POS_W-1:0]   res_start_q;
	status_t            res_status_q;
	logic [START_W-1:0] out_start_q;
	status_t            out_status_q;

	// datapath helpers
	logic [KEY_W-1:0]  chk_key;
	logic [POS_W-1:0]  chk_start, chk_end;
	logic              len_ok, range_ok, fit_left;
	logic [NODE_W-1:0] desc_next, up_par;
	logic [POS_W-1:0]  found_bend, split_start, split_len, up_max, put_len;
	logic [POS_W:0]    nxt_end, ps_end;
	logic              clr_pow2, clr_last;

	assign {chk_key, chk_start, chk_end} = slot_rdata;
	assign len_ok = (32'(req_q) >= 32'd1) && (32'(req_q) <= 32'(ARENA_WORDS));
	assign range_ok = (hit_start_q != '0) && (hit_start_q <= hit_end_q)
		&& (hit_end_q <= ARENA_POS);
	assign fit_left   = tree_rdata >= len_q;
	assign desc_next  = {node_q[NODE_W-2:0], ~fit_left};
	assign up_par     = node_q >> 1;
	assign up_max     = (tree_rdata > cur_q) ? tree_rdata : cur_q;
	assign found_bend = pos_q + fl_rdata - POS_W'(1);
	assign split_start = pos_q + len_q;
	assign split_len  = bend_q - split_start + POS_W'(1);
	assign nxt_end    = {1'b0, e_q} + {1'b0, fl_rdata};
	assign ps_end     = {1'b0, ps_q} + {1'b0, fl_rdata} - (POS_W+1)'(1);
	assign put_len    = e_q - s_q + POS_W'(1);
	assign clr_pow2   = (clr_q != '0) && ((clr_q & (clr_q - NODE_W'(1))) == '0);
	assign clr_last   = &clr_q;

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_vld_q;
	assign rsp.start_position = out_start_q;
	assign rsp.status         = out_status_q;

	always_comb begin
		state_d    = state_q;
		tree_we    = 1'b0;
		tree_waddr = '0;
		tree_wdata = '0;
		tree_raddr = '0;
		fl_we      = 1'b0;
		fl_waddr   = '0;
		fl_wdata   = '0;
		fl_raddr   = '0;
		fse_we     = 1'b0;
		fse_waddr  = '0;
		fse_wdata  = '0;
		fse_raddr  = '0;
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = {key_q, {POS_W{1'b0}}, {POS_W{1'b0}}};
		slot_raddr = scan_idx_q;
		case (state_q)
			S_CLEAR: begin
				// only the leftmost path holds the arena size at start
				tree_we    = 1'b1;
				tree_waddr = clr_q;
				tree_wdata = clr_pow2 ? ARENA_POS : '0;
				fl_we      = 32'(clr_q) < 32'(ARENA_WORDS);
				fl_waddr   = clr_q[IDX_W-1:0];
				fl_wdata   = (clr_q == '0) ? ARENA_POS : '0;
				fse_we     = fl_we;
				fse_waddr  = clr_q[IDX_W-1:0];
				fse_wdata  = (32'(clr_q) == 32'(ARENA_WORDS - 1)) ? POS_W'(1) : '0;
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd.valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (32'(scan_idx_q) == 32'(HANDLE_SLOTS - 1)) state_d = S_SCAN_LAST;
			end
			S_SCAN_LAST: state_d = S_DECIDE;
			S_DECIDE: begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (!found_q && !free_found_q) state_d = S_RESP;
						else if (len_ok) state_d = S_A_ROOT_RD;
						else state_d = S_A_FAIL;
					end
					CMD_FREE: begin
						if (found_q && hit_end_q != '0) state_d = S_F_START;
						else state_d = S_RESP;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_A_ROOT_RD: begin
				tree_raddr = NODE_W'(1);
				state_d    = S_A_ROOT_CK;
			end
			S_A_ROOT_CK: begin
				state_d = fit_left ? S_A_DESC_RD : S_A_FAIL;
			end
			S_A_DESC_RD: begin
				tree_raddr = {node_q[NODE_W-2:0], 1'b0};
				state_d    = S_A_DESC_CK;
			end
			S_A_DESC_CK: begin
				state_d = desc_next[LEAF_W] ? S_A_FOUND_RD : S_A_DESC_RD;
			end
			S_A_FOUND_RD: begin
				fl_raddr = node_q[IDX_W-1:0];
				state_d  = S_A_FOUND_CK;
			end
			S_A_FOUND_CK: begin
				fl_we      = 1'b1;
				fl_waddr   = IDX_W'(pos_q - POS_W'(1));
				fse_we     = 1'b1;
				fse_waddr  = IDX_W'(found_bend - POS_W'(1));
				slot_we    = 1'b1;
				slot_wdata = {key_q, pos_q, pos_q + len_q - POS_W'(1)};
				state_d    = S_LEAF_WR;
			end
			S_A_SPLIT: begin
				if (blen_q > len_q) begin
					fl_we     = 1'b1;
					fl_waddr  = IDX_W'(split_start - POS_W'(1));
					fl_wdata  = split_len;
					fse_we    = 1'b1;
					fse_waddr = IDX_W'(bend_q - POS_W'(1));
					fse_wdata = split_start;
					state_d   = S_LEAF_WR;
				end else begin
					state_d = S_RESP;
				end
			end
			S_A_FAIL: begin
				slot_we = 1'b1;
				state_d = S_RESP;
			end
			S_F_START: begin
				slot_we    = 1'b1;
				slot_waddr = fslot_q;
				fl_raddr   = hit_end_q[IDX_W-1:0];
				state_d    = range_ok ? S_F_NXT_CK : S_RESP;
			end
			S_F_NXT_CK: begin
				if (e_q < ARENA_POS && fl_rdata != '0) begin
					fl_we     = 1'b1;
					fl_waddr  = e_q[IDX_W-1:0];
					fse_we    = (nxt_end != '0) && (nxt_end <= {1'b0, ARENA_POS});
					fse_waddr = IDX_W'(nxt_end - (POS_W+1)'(1));
					state_d   = S_LEAF_WR;
				end else begin
					state_d = S_F_PRV_RD;
				end
			end
			S_F_PRV_RD: begin
				fse_raddr = IDX_W'(s_q - POS_W'(2));
				state_d   = (s_q > POS_W'(1)) ? S_F_PRV_CK : S_F_PUT;
			end
			S_F_PRV_CK: begin
				fl_raddr = IDX_W'(fse_rdata - POS_W'(1));
				state_d  = (fse_rdata != '0) ? S_F_PS_CK : S_F_PUT;
			end
			S_F_PS_CK: begin
				fl_we     = 1'b1;
				fl_waddr  = IDX_W'(ps_q - POS_W'(1));
				fse_we    = (ps_end != '0) && (ps_end <= {1'b0, ARENA_POS});
				fse_waddr = IDX_W'(ps_end - (POS_W+1)'(1));
				state_d   = S_LEAF_WR;
			end
			S_F_PUT: begin
				fl_we     = 1'b1;
				fl_waddr  = IDX_W'(s_q - POS_W'(1));
				fl_wdata  = put_len;
				fse_we    = 1'b1;
				fse_waddr = IDX_W'(e_q - POS_W'(1));
				fse_wdata = s_q;
				state_d   = S_LEAF_WR;
			end
			S_LEAF_WR: begin
				tree_we    = 1'b1;
				tree_waddr = {1'b1, leaf_idx_q};
				tree_wdata = leaf_v_q;
				state_d    = S_UP_RD;
			end
			S_UP_RD: begin
				tree_raddr = node_q ^ NODE_W'(1);
				state_d    = S_UP_WR;
			end
			S_UP_WR: begin
				tree_we    = 1'b1;
				tree_waddr = up_par;
				tree_wdata = up_max;
				state_d    = (up_par == NODE_W'(1)) ? ret_q : S_UP_RD;
			end
			S_RESP: begin
				if (!out_vld_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			used_q       <= '0;
			out_vld_q    <= 1'b0;
			scan_idx_q   <= '0;
			chk_vld_s1   <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) clr_q <= clr_q + NODE_W'(1);
			chk_vld_s1 <= (state_q == S_SCAN);
			if (state_q == S_IDLE) begin
				scan_idx_q   <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (state_q == S_SCAN) scan_idx_q <= scan_idx_q + SLOT_W'(1);
			if (chk_vld_s1) begin
				if (used_q[chk_idx_s1] && chk_key == key_q && !found_q) found_q <= 1'b1;
				if (!used_q[chk_idx_s1] && !free_found_q) free_found_q <= 1'b1;
			end
			if (state_q == S_DECIDE && cmd_q == CMD_ALLOC && (found_q || free_found_q)) begin
				used_q[found_q ? fslot_q : free_slot_q] <= 1'b1;
			end
			if (state_q == S_RESP && (!out_vld_q || rsp.ready)) out_vld_q <= 1'b1;
			else if (rsp.valid && rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= scan_idx_q;
		if (state_q == S_IDLE && cmd.valid) begin
			cmd_q <= cmd_t'(cmd.command);
			key_q <= cmd.handle_name;
			req_q <= cmd.request_length;
		end
		if (chk_vld_s1) begin
			if (used_q[chk_idx_s1] && chk_key == key_q && !found_q) begin
				fslot_q     <= chk_idx_s1;
				hit_start_q <= chk_start;
				hit_end_q   <= chk_end;
			end
			if (!used_q[chk_idx_s1] && !free_found_q) free_slot_q <= chk_idx_s1;
		end
		case (state_q)
			S_DECIDE: begin
				len_q        <= POS_W'(req_q);
				slot_q       <= found_q ? fslot_q : free_slot_q;
				res_start_q  <= (cmd_q == CMD_QUERY && found_q) ? hit_start_q : '0;
				res_status_q <= (cmd_q == CMD_ALLOC && !found_q && !free_found_q)
					? STAT_FULL : STAT_OK;
				s_q <= hit_start_q;
				e_q <= hit_end_q;
			end
			S_A_ROOT_CK: node_q <= NODE_W'(1);
			S_A_DESC_CK: begin
				node_q <= desc_next;
				pos_q  <= POS_W'(desc_next[LEAF_W-1:0]) + POS_W'(1);
			end
			S_A_FOUND_CK: begin
				blen_q      <= fl_rdata;
				bend_q      <= found_bend;
				leaf_idx_q  <= IDX_W'(pos_q - POS_W'(1));
				leaf_v_q    <= '0;
				ret_q       <= S_A_SPLIT;
				res_start_q <= pos_q;
			end
			S_A_SPLIT: begin
				leaf_idx_q <= IDX_W'(split_start - POS_W'(1));
				leaf_v_q   <= split_len;
				ret_q      <= S_RESP;
			end
			S_A_FAIL: res_status_q <= STAT_NOFIT;
			S_F_NXT_CK: begin
				leaf_idx_q <= e_q[IDX_W-1:0];
				leaf_v_q   <= '0;
				ret_q      <= S_F_PRV_RD;
				if (e_q < ARENA_POS && fl_rdata != '0) e_q <= POS_W'(nxt_end);
			end
			S_F_PRV_CK: ps_q <= fse_rdata;
			S_F_PS_CK: begin
				leaf_idx_q <= IDX_W'(ps_q - POS_W'(1));
				leaf_v_q   <= '0;
				ret_q      <= S_F_PUT;
				s_q        <= ps_q;
			end
			S_F_PUT: begin
				leaf_idx_q <= IDX_W'(s_q - POS_W'(1));
				leaf_v_q   <= put_len;
				ret_q      <= S_RESP;
			end
			S_LEAF_WR: begin
				node_q <= {1'b1, leaf_idx_q};
				cur_q  <= leaf_v_q;
			end
			S_UP_WR: begin
				node_q <= up_par;
				cur_q  <= up_max;
			end
			S_RESP: begin
				if (!out_vld_q || rsp.ready) begin
					out_start_q  <= START_W'(res_start_q);
					out_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/ffa_ram.sv
`default_nettype none
module ffa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
